// File: rtl/nmh_pkg.sv
// Shared types and constants for the Sobel normal-map block.
package nmh_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_IMG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_BUMP_STRENGTH = 2'd2;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 13;

    localparam logic [12:0] HEIGHT_MAX = 13'd4096;

    // 255 * 256: unit length of the z component
    localparam logic signed [23:0] KSCALE   = 24'sd65280;
    localparam logic [45:0]        KSQ      = 46'd4261478400;
    localparam logic signed [41:0] KOFS     = 42'sd4278190080;
    localparam logic [22:0]        DIV_INIT = 23'd32640;
    localparam logic [31:0]        DIV_NUM  = 32'd4278190080;

    localparam int JOB_DEPTH = 4;

    typedef struct packed {
        logic [7:0] height_sample;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  normal_x;
        logic [7:0]  normal_y;
        logic [7:0]  normal_z;
        logic [11:0] out_col;
        logic [11:0] out_row;
        logic        last_of_run;
    } t_nrm_out;

    // One output pixel waiting for the normal computation
    typedef struct packed {
        logic signed [10:0] dx;
        logic signed [10:0] dy;
        logic [11:0]        col;
        logic [11:0]        row;
        logic               last;
    } t_job;

endpackage

// File: rtl/normal_map_from_height_sobel.sv
// Sobel normal map from a streamed height map: top level and config registers.
//
// Input channel: i_valid / o_stall carry one 8-bit height pixel per
// transaction in raster order; frame_start puts the pixel at (0,0). A
// pixel is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry one normal pixel per transaction
// (x, y, z bytes, column, row, and last_of_run on the final normal caused
// by one input pixel). A pixel causes zero to four normals, in raster order.
// The front end raises o_stall while it updates the window and pushes the
// normals of the last pixel, and waits while the job queue is full; it takes
// no new pixel before it is through with the last one.
// The back end computes one normal at a time with the bit-serial square root
// and reciprocal divide that all normals share, and takes no new job from
// the queue before its current normal is in the output register.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
// (0 width, 1 height, 2 strength). The user writes only while the block is
// idle; the block itself does not enforce this.
// Reset (synchronous, active low) clears counters, window and queues and
// loads width 4096, height 4096, strength 1.0; line buffers are not cleared.
// While the receiver stalls, the result holds and the back end waits.
module normal_map_from_height_sobel #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  nmh_pkg::t_pix_in        i_pix,
    output logic                    o_stall,
    output logic                    o_valid,
    output nmh_pkg::t_nrm_out       o_nrm,
    input  logic                    i_stall,
    input  logic                    i_cfg_we,
    input  logic [nmh_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [nmh_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import nmh_pkg::*;

    logic [12:0] r_img_width;
    logic [12:0] r_img_height;
    logic [11:0] r_bump_strength;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width     <= 13'd4096;
            r_img_height    <= 13'd4096;
            r_bump_strength <= 12'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IMG_WIDTH:     r_img_width     <= i_cfg_wdata;
                CFG_IMG_HEIGHT:    r_img_height    <= i_cfg_wdata;
                CFG_BUMP_STRENGTH: r_bump_strength <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    nmh_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pix       (i_pix),
        .o_stall     (o_stall),
        .i_img_width (r_img_width),
        .i_img_height(r_img_height),
        .o_push      (push),
        .o_job       (job_in),
        .i_full      (full)
    );

    nmh_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (job_in),
        .o_full (full),
        .i_pop  (pop),
        .o_data (job_out),
        .o_empty(empty)
    );

    nmh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (job_out),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_strength(r_bump_strength),
        .o_valid   (o_valid),
        .o_nrm     (o_nrm),
        .i_stall   (i_stall)
    );

endmodule

// File: rtl/nmh_front.sv
// Front end: position counters, line buffers, 3x3 window and Sobel gradients.
module nmh_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  nmh_pkg::t_pix_in i_pix,
    output logic           o_stall,
    input  logic [12:0]    i_img_width,
    input  logic [12:0]    i_img_height,
    output logic           o_push,
    output nmh_pkg::t_job  o_job,
    input  logic           i_full
);
    import nmh_pkg::*;

    localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > 13) ? WW : 13;

    typedef enum logic [1:0] {F_IDLE, F_UPD, F_EMIT} t_fstate;

    t_fstate r_state;

    logic [7:0] mem_up  [MAX_WIDTH];
    logic [7:0] mem_mid [MAX_WIDTH];
    logic [7:0] r_rd_up;
    logic [7:0] r_rd_mid;

    logic [2:0][2:0][7:0] r_win;
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic [CW-1:0] r_c;
    logic [11:0]   r_r;
    logic [7:0]    r_pix;
    logic          r_c_last;
    logic          r_r_last;
    logic [3:0]    r_mask;

    logic [WW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic [CW-1:0] c_pre;
    logic [11:0]   r_pre;
    logic [12:0]   row_inc;
    logic [WW-1:0] col_inc;
    logic [CW-1:0] n_col;
    logic [11:0]   n_row;
    logic [12:0]   row_post;
    logic          accept;

    logic [1:0] k_sel;
    logic [3:0] k_bit;
    logic       x_is_c;
    logic       y_is_r;
    logic       x_zero;
    logic       y_zero;
    logic [1:0] cc;
    logic [1:0] lc;
    logic [1:0] cr;
    logic [1:0] tr;
    logic [9:0] s_l;
    logic [9:0] s_r;
    logic [9:0] s_t;
    logic [9:0] s_b;

    function automatic logic [7:0] px(input logic [2:0][2:0][7:0] w,
                                      input logic [1:0] row, input logic [1:0] col);
        logic [2:0][7:0] line;
        case (row)
            2'd0:    line = w[0];
            2'd1:    line = w[1];
            default: line = w[2];
        endcase
        case (col)
            2'd0:    px = line[0];
            2'd1:    px = line[1];
            default: px = line[2];
        endcase
    endfunction

    // effective size, clamped to the supported range
    always_comb begin
        if (i_img_width == 13'd0) begin
            w_eff = WW'(1);
        end else if (CMPW'(i_img_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_img_width);
        end
        if (i_img_height == 13'd0) begin
            h_eff = 13'd1;
        end else if (i_img_height > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end else begin
            h_eff = i_img_height;
        end
    end

    // position of the incoming pixel, then the position after it
    always_comb begin
        row_inc = 13'(r_row) + 13'd1;
        if (i_pix.frame_start) begin
            c_pre = '0;
            r_pre = '0;
        end else if (WW'(r_col) >= w_eff) begin
            c_pre = '0;
            r_pre = (row_inc >= h_eff) ? 12'd0 : row_inc[11:0];
        end else begin
            c_pre = r_col;
            r_pre = (13'(r_row) >= h_eff) ? 12'd0 : r_row;
        end
        col_inc  = WW'(c_pre) + WW'(1);
        row_post = 13'(r_pre) + 13'd1;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_post >= h_eff) ? 12'd0 : row_post[11:0];
        end else begin
            n_col = CW'(col_inc);
            n_row = r_pre;
        end
    end

    assign accept  = i_valid && (r_state == F_IDLE);
    assign o_stall = (r_state != F_IDLE);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_up  <= mem_up[c_pre];
            r_rd_mid <= mem_mid[c_pre];
        end
        if (r_state == F_UPD) begin
            mem_up[r_c]  <= r_rd_mid;
            mem_mid[r_c] <= r_pix;
        end
    end

    // pick the lowest pending output of this pixel
    always_comb begin
        if (r_mask[0]) begin
            k_sel = 2'd0;
        end else if (r_mask[1]) begin
            k_sel = 2'd1;
        end else if (r_mask[2]) begin
            k_sel = 2'd2;
        end else begin
            k_sel = 2'd3;
        end
        k_bit  = 4'(1) << k_sel;
        x_is_c = k_sel[0];
        y_is_r = k_sel[1];
        x_zero = x_is_c ? (r_c == '0) : (r_c == CW'(1));
        y_zero = y_is_r ? (r_r == 12'd0) : (r_r == 12'd1);
        cc     = x_is_c ? 2'd2 : 2'd1;
        cr     = y_is_r ? 2'd2 : 2'd1;
        lc     = x_zero ? cc : cc - 2'd1;
        tr     = y_zero ? cr : cr - 2'd1;
        // right column and bottom row are always the newest ones
        s_l = 10'(px(r_win, tr, lc)) + {1'b0, px(r_win, cr, lc), 1'b0}
            + 10'(px(r_win, 2'd2, lc));
        s_r = 10'(px(r_win, tr, 2'd2)) + {1'b0, px(r_win, cr, 2'd2), 1'b0}
            + 10'(px(r_win, 2'd2, 2'd2));
        s_t = 10'(px(r_win, tr, lc)) + {1'b0, px(r_win, tr, cc), 1'b0}
            + 10'(px(r_win, tr, 2'd2));
        s_b = 10'(px(r_win, 2'd2, lc)) + {1'b0, px(r_win, 2'd2, cc), 1'b0}
            + 10'(px(r_win, 2'd2, 2'd2));
        o_job.dx   = $signed({1'b0, s_r}) - $signed({1'b0, s_l});
        o_job.dy   = $signed({1'b0, s_b}) - $signed({1'b0, s_t});
        o_job.col  = 12'(x_is_c ? r_c : r_c - CW'(1));
        o_job.row  = y_is_r ? r_r : r_r - 12'd1;
        o_job.last = ((r_mask & ~k_bit) == 4'd0);
    end

    assign o_push = (r_state == F_EMIT) && (r_mask != 4'd0) && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_win   <= '0;
            r_mask  <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_c      <= c_pre;
                        r_r      <= r_pre;
                        r_pix    <= i_pix.height_sample;
                        r_c_last <= (WW'(c_pre) == w_eff - WW'(1));
                        r_r_last <= (13'(r_pre) == h_eff - 13'd1);
                        r_col    <= n_col;
                        r_row    <= n_row;
                        r_state  <= F_UPD;
                    end
                end
                F_UPD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_win[i][0] <= r_win[i][1];
                        r_win[i][1] <= r_win[i][2];
                    end
                    r_win[0][2] <= r_rd_up;
                    r_win[1][2] <= r_rd_mid;
                    r_win[2][2] <= r_pix;
                    r_mask[0] <= (r_r != 12'd0) && (r_c != '0);
                    r_mask[1] <= (r_r != 12'd0) && r_c_last;
                    r_mask[2] <= r_r_last && (r_c != '0);
                    r_mask[3] <= r_r_last && r_c_last;
                    if ((r_r != 12'd0) || r_r_last) begin
                        r_state <= F_EMIT;
                    end else begin
                        r_state <= F_IDLE;
                    end
                end
                F_EMIT: begin
                    if (r_mask == 4'd0) begin
                        r_state <= F_IDLE;
                    end else if (!i_full) begin
                        r_mask <= r_mask & ~k_bit;
                        if ((r_mask & ~k_bit) == 4'd0) begin
                            r_state <= F_IDLE;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/nmh_fifo.sv
// Short job queue between the front end and the normal computation.
module nmh_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nmh_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output nmh_pkg::t_job o_data,
    output logic          o_empty
);
    import nmh_pkg::*;

    localparam int PW = $clog2(JOB_DEPTH);

    t_job r_mem [JOB_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(JOB_DEPTH)) else $error("queue count out of range");
    a_first_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && i_push) |=> (o_data == $past(i_data)))
        else $error("job into empty queue not at head");

endmodule

// File: rtl/nmh_back.sv
// Back end: scaling, vector length, reciprocal and byte mapping of one normal.
module nmh_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nmh_pkg::t_job   i_job,
    input  logic            i_empty,
    output logic            o_pop,
    input  logic [11:0]     i_strength,
    output logic            o_valid,
    output nmh_pkg::t_nrm_out o_nrm,
    input  logic            i_stall
);
    import nmh_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_SCALE, B_SQUARE, B_SUM, B_SQRT, B_DIV, B_MAP, B_OUT
    } t_bstate;

    t_bstate r_state;
    t_job    r_job;
    logic signed [23:0] r_a;
    logic signed [23:0] r_b;
    logic [45:0] r_aa;
    logic [45:0] r_bb;
    logic [45:0] r_rem;
    logic [45:0] r_root;
    logic [45:0] r_bit;
    logic [4:0]  r_cnt;
    logic [22:0] r_drem;
    logic [16:0] r_quo;
    logic signed [41:0] r_ta;
    logic signed [41:0] r_tb;
    logic signed [41:0] r_tk;
    logic        r_oval;
    t_nrm_out    r_nrm;

    logic signed [23:0] w_pa;
    logic signed [23:0] w_pb;
    logic signed [47:0] w_aa;
    logic signed [47:0] w_bb;
    logic [45:0] w_trial;
    logic [23:0] w_dtmp;
    logic signed [41:0] w_ta;
    logic signed [41:0] w_tb;
    logic signed [41:0] w_tk;
    logic out_free;

    function automatic logic [7:0] map_byte(input logic signed [41:0] t);
        logic signed [41:0] num;
        num = t + KOFS;
        if (num[41]) begin
            map_byte = 8'd0;
        end else if (|num[40:33]) begin
            map_byte = 8'd255;
        end else begin
            map_byte = num[32:25];
        end
    endfunction

    assign w_pa    = $signed(r_job.dx) * $signed({1'b0, i_strength});
    assign w_pb    = $signed(r_job.dy) * $signed({1'b0, i_strength});
    assign w_aa    = r_a * r_a;
    assign w_bb    = r_b * r_b;
    assign w_trial = r_root + r_bit;
    assign w_dtmp  = {r_drem, DIV_NUM[r_cnt]};
    assign w_ta    = r_a * $signed({1'b0, r_quo});
    assign w_tb    = r_b * $signed({1'b0, r_quo});
    assign w_tk    = KSCALE * $signed({1'b0, r_quo});
    assign out_free = !r_oval || !i_stall;

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = r_oval;
    assign o_nrm   = r_nrm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_oval  <= 1'b0;
        end else begin
            // a new result in B_OUT takes over the valid flag
            if (r_oval && !i_stall && (r_state != B_OUT)) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_state <= B_SCALE;
                    end
                end
                B_SCALE: begin
                    r_a     <= -w_pa;
                    r_b     <= -w_pb;
                    r_state <= B_SQUARE;
                end
                B_SQUARE: begin
                    r_aa    <= w_aa[45:0];
                    r_bb    <= w_bb[45:0];
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_rem   <= r_aa + r_bb + KSQ;
                    r_root  <= '0;
                    r_bit   <= 46'd1 << 44;
                    r_cnt   <= 5'd22;
                    r_state <= B_SQRT;
                end
                B_SQRT: begin
                    // one result bit per cycle
                    if (r_rem >= w_trial) begin
                        r_rem  <= r_rem - w_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 5'd0) begin
                        r_drem  <= DIV_INIT;
                        r_quo   <= '0;
                        r_cnt   <= 5'd16;
                        r_state <= B_DIV;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                B_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (w_dtmp >= {1'b0, r_root[22:0]}) begin
                        r_drem <= 23'(w_dtmp - {1'b0, r_root[22:0]});
                        r_quo  <= {r_quo[15:0], 1'b1};
                    end else begin
                        r_drem <= w_dtmp[22:0];
                        r_quo  <= {r_quo[15:0], 1'b0};
                    end
                    if (r_cnt == 5'd0) begin
                        r_state <= B_MAP;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                B_MAP: begin
                    r_ta    <= w_ta;
                    r_tb    <= w_tb;
                    r_tk    <= w_tk;
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        r_nrm.normal_x    <= map_byte(r_ta);
                        r_nrm.normal_y    <= map_byte(r_tb);
                        r_nrm.normal_z    <= map_byte(r_tk);
                        r_nrm.out_col     <= r_job.col;
                        r_nrm.out_row     <= r_job.row;
                        r_nrm.last_of_run <= r_job.last;
                        r_oval            <= 1'b1;
                        r_state           <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SQRT) |-> $onehot(r_bit)) else $error("root bit not one-hot");
    a_root_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_root[22:0] >= 23'(KSCALE)))
        else $error("vector length below unit z");
    a_inv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MAP) |-> (r_quo <= 17'h10000))
        else $error("reciprocal above one");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT && !out_free) |=> (r_state == B_OUT))
        else $error("result dropped while output busy");

endmodule
